/* sv/m61alu_pkg.sv */
// ----------------------------------------------------------------------------
// m61alu_pkg
// shared constants, operation codes and the 64-bit to residue fold
// for arithmetic modulo the prime 2^61 - 1
// ----------------------------------------------------------------------------
package m61alu_pkg;

    localparam int unsigned RES_W  = 61;
    localparam int unsigned OPND_W = 64;
    localparam int unsigned EXP_W  = 63;
    localparam int unsigned FUNC_W = 3;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned HI_W   = RES_W - HALF_W;

    // request tdata: first, second, exponent; padded to whole bytes
    localparam int unsigned IN_DATA_W  = 192;
    // result tdata: result, equal; padded to whole bytes
    localparam int unsigned OUT_DATA_W = 64;

    typedef logic [RES_W-1:0]  t_res;
    typedef logic [FUNC_W-1:0] t_func;

    localparam t_res MODP     = {RES_W{1'b1}};
    localparam t_res INV_EXP  = MODP - t_res'(2);
    localparam t_res RES_ONE  = t_res'(1);

    localparam t_func FUNC_ADD = 3'd0;
    localparam t_func FUNC_SUB = 3'd1;
    localparam t_func FUNC_MUL = 3'd2;
    localparam t_func FUNC_DIV = 3'd3;
    localparam t_func FUNC_POW = 3'd4;
    localparam t_func FUNC_INV = 3'd5;

    function automatic t_res fold61(input logic [OPND_W-1:0] x);
        logic [RES_W:0] s;
        s = {1'b0, x[RES_W-1:0]} + {{(RES_W+1-(OPND_W-RES_W)){1'b0}}, x[OPND_W-1:RES_W]};
        if (s >= {1'b0, MODP}) begin
            s = s - {1'b0, MODP};
        end
        return s[RES_W-1:0];
    endfunction

endpackage

/* sv/mersenne61_modular_alu.sv */
// ----------------------------------------------------------------------------
// mersenne61_modular_alu
// modular arithmetic unit over p = 2^61 - 1 with a shared 32x32 multiplier
// ----------------------------------------------------------------------------
// usage:
//   slave channel i_s_*: one request per item; tuser carries the operation
//   code (0 add, 1 subtract, 2 multiply, 3 divide, 4 power, 5 inverse),
//   tdata carries both raw 64-bit operands and the 63-bit exponent.
//   master channel o_m_*: one result per request, the residue and the
//   equal flag of the reduced operands.
//   o_s_tready is high only while the sequencer is idle; one request is
//   worked on at a time.
//   add, subtract and unused codes finish without the multiplier; multiply
//   takes one modular product. every modular product goes through one
//   32x32 multiplier in 4 partial products plus accumulate and fold. power
//   squares for each exponent bit and multiplies for each set bit, up to the
//   top set bit; inverse runs the 61-bit exponent p-2, divide the same with
//   one product more. the next request can be taken in the cycle after a
//   result is loaded.
//   a finished result sits in the output register while the next request
//   is taken; if the receiver stalls and that register is still full, the
//   sequencer holds in its final state until the register drains.
//   synchronous active-low reset empties the output and idles the sequencer.
// ----------------------------------------------------------------------------
module mersenne61_modular_alu (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // bits up from 0: first_operand[63:0], second_operand[127:64],
    // exponent[190:128], zero pad[191]
    input  logic [m61alu_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // bits up from 0: func[2:0]
    input  logic [m61alu_pkg::FUNC_W-1:0]       i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // bits up from 0: result[60:0], equal[61], zero pad[63:62]
    output logic [m61alu_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import m61alu_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MACC  = 3'd3;
    localparam logic [2:0] S_MSQ   = 3'd4;
    localparam logic [2:0] S_MFIN  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [2:0] MSTEP_LAST = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [2:0]         r_mstep, n_mstep;
    t_func              r_func, n_func;
    t_res               r_a, n_a;
    t_res               r_b, n_b;
    logic [EXP_W-1:0]   r_e, n_e;
    t_res               r_acc, n_acc;
    t_res               r_sq, n_sq;
    t_res               r_res, n_res;
    logic               r_eq, n_eq;
    logic [OPND_W-1:0]  r_prod, n_prod;
    logic [OPND_W-1:0]  r_sum, n_sum;
    logic               r_out_valid, n_out_valid;
    t_res               r_out_res, n_out_res;
    logic               r_out_eq, n_out_eq;

    logic               in_acc;
    logic               in_mul;
    t_res               mx, my;
    logic [HALF_W-1:0]  mul_x, mul_y;
    logic [OPND_W-1:0]  term;
    t_res               mul_res;
    logic [RES_W:0]     add_sum;
    logic [RES_W:0]     sub_dif;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign in_mul     = (r_state == S_MACC) || (r_state == S_MSQ) || (r_state == S_MFIN);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-RES_W-1){1'b0}}, r_out_eq, r_out_res};

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_MACC: begin
                mx = r_acc;
                my = r_sq;
            end
            S_MSQ: begin
                mx = r_sq;
                my = r_sq;
            end
            default: begin
                mx = r_a;
                my = r_acc;
            end
        endcase
    end

    always_comb begin
        mul_x = r_mstep[1] ? {{(HALF_W-HI_W){1'b0}}, mx[RES_W-1:HALF_W]} : mx[HALF_W-1:0];
        mul_y = r_mstep[0] ? {{(HALF_W-HI_W){1'b0}}, my[RES_W-1:HALF_W]} : my[HALF_W-1:0];
    end

    // partial product weighted and reduced: low*low, two cross terms, high*high
    always_comb begin
        unique case (r_mstep)
            3'd1:      term = {{(OPND_W-RES_W){1'b0}}, fold61(r_prod)};
            3'd2,
            3'd3:      term = {{(OPND_W-RES_W){1'b0}}, r_prod[HI_W-1:0], {HALF_W{1'b0}}}
                            + {{HI_W{1'b0}}, r_prod[OPND_W-1:HI_W]};
            3'd4:      term = {r_prod[OPND_W-4:0], 3'b000};
            default:   term = '0;
        endcase
    end

    assign mul_res = fold61(r_sum);
    assign add_sum = {1'b0, r_a} + {1'b0, r_b};
    assign sub_dif = {1'b0, r_a} - {1'b0, r_b};

    always_comb begin
        n_state     = r_state;
        n_mstep     = r_mstep;
        n_func      = r_func;
        n_a         = r_a;
        n_b         = r_b;
        n_e         = r_e;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_res       = r_res;
        n_eq        = r_eq;
        n_prod      = r_prod;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out_res   = r_out_res;
        n_out_eq    = r_out_eq;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        if (in_mul) begin
            n_prod = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
            if (r_mstep == 3'd0) begin
                n_sum = '0;
            end else begin
                n_sum = r_sum + term;
            end
            if (r_mstep == MSTEP_LAST) begin
                n_mstep = '0;
            end else begin
                n_mstep = r_mstep + 3'd1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func  = i_s_tuser;
                    n_a     = fold61(i_s_tdata[OPND_W-1:0]);
                    n_b     = fold61(i_s_tdata[2*OPND_W-1:OPND_W]);
                    n_e     = i_s_tdata[2*OPND_W+EXP_W-1:2*OPND_W];
                    n_state = S_START;
                end
            end
            S_START: begin
                n_eq  = (r_a == r_b);
                n_acc = RES_ONE;
                unique case (r_func)
                    FUNC_ADD: begin
                        n_res   = (add_sum >= {1'b0, MODP}) ? t_res'(add_sum - {1'b0, MODP})
                                                            : add_sum[RES_W-1:0];
                        n_state = S_DONE;
                    end
                    FUNC_SUB: begin
                        n_res   = (r_a >= r_b) ? sub_dif[RES_W-1:0]
                                               : t_res'(sub_dif + {1'b0, MODP});
                        n_state = S_DONE;
                    end
                    FUNC_MUL: begin
                        n_acc   = r_b;
                        n_state = S_MFIN;
                    end
                    FUNC_DIV: begin
                        n_sq    = r_b;
                        n_e     = {{(EXP_W-RES_W){1'b0}}, INV_EXP};
                        n_state = S_CHECK;
                    end
                    FUNC_POW: begin
                        n_sq    = r_a;
                        n_state = S_CHECK;
                    end
                    FUNC_INV: begin
                        n_sq    = r_a;
                        n_e     = {{(EXP_W-RES_W){1'b0}}, INV_EXP};
                        n_state = S_CHECK;
                    end
                    default: begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_CHECK: begin
                priority if (r_e == '0) begin
                    if (r_func == FUNC_DIV) begin
                        n_state = S_MFIN;
                    end else begin
                        n_res   = r_acc;
                        n_state = S_DONE;
                    end
                end else if (r_e[0]) begin
                    n_state = S_MACC;
                end else begin
                    n_state = S_MSQ;
                end
            end
            S_MACC: begin
                if (r_mstep == MSTEP_LAST) begin
                    n_acc   = mul_res;
                    n_state = S_MSQ;
                end
            end
            S_MSQ: begin
                if (r_mstep == MSTEP_LAST) begin
                    n_sq    = mul_res;
                    n_e     = r_e >> 1;
                    n_state = S_CHECK;
                end
            end
            S_MFIN: begin
                if (r_mstep == MSTEP_LAST) begin
                    n_res   = mul_res;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_res;
                    n_out_eq    = r_eq;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mstep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mstep     <= n_mstep;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_a       <= n_a;
        r_b       <= n_b;
        r_e       <= n_e;
        r_acc     <= n_acc;
        r_sq      <= n_sq;
        r_res     <= n_res;
        r_eq      <= n_eq;
        r_prod    <= n_prod;
        r_sum     <= n_sum;
        r_out_res <= n_out_res;
        r_out_eq  <= n_out_eq;
    end

endmodule
